[sv/rgb565_alpha_compositor_core_assert.svh]
// Assertion macros for the RGB565 alpha compositor.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
`ifndef RGB565_ALPHA_COMPOSITOR_CORE_ASSERT_SVH
`define RGB565_ALPHA_COMPOSITOR_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RGBCMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds a fixed number of cycles after the antecedent.
`define RGBCMP_ASSERT_AFTER(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##dly (cons)) else $error(msg);

`endif

[sv/rgbcmp_pkg.sv]
`timescale 1ns / 1ps

package rgbcmp_pkg;

	// Largest frame dimension supported by default.
	localparam int MAX_DIM_DEFAULT = 1024;

	localparam int REG_W   = 11;
	localparam int COORD_W = 10;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 16;
	localparam int IDX_W   = 20;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ORIGIN_X    = 2'd0,
		REG_ORIGIN_Y    = 2'd1,
		REG_DEST_WIDTH  = 2'd2,
		REG_DEST_HEIGHT = 2'd3
	} reg_index_t;

	localparam logic [REG_W-1:0] DEST_WIDTH_RESET  = 11'd320;
	localparam logic [REG_W-1:0] DEST_HEIGHT_RESET = 11'd240;

	localparam logic [CHAN_W-1:0] ALPHA_MIN    = 8'd8;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd250;
	localparam logic [CHAN_W-1:0] ALPHA_FULL   = 8'd255;

	// Exact floor(x / 255) for any x up to 255 * 255.
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [PIX_W-1:0] pack565(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

[sv/rgb565_alpha_compositor_core.sv]
// RGB565 alpha compositor: throughput is one pixel per clock. Three register
// stages (input, multiply, divide-and-pack) lie between the accepting edge and
// the result_valid cycle.
// busy and cfg_ready stay low and high; the receiver cannot stall results.
// arst_n clears the valid pipeline and loads the register reset values.
`timescale 1ns / 1ps

`include "rgb565_alpha_compositor_core_assert.svh"

module rgb565_alpha_compositor_core #(
	parameter int MAX_DIM = rgbcmp_pkg::MAX_DIM_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel transaction in.
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  rel_x,
	input  logic [9:0]  rel_y,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	input  logic [15:0] dest_pixel,
	// Configuration write transaction.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_wdata,
	// Result transaction out.
	output logic        result_valid,
	output logic        write_enable,
	output logic [19:0] dest_index,
	output logic [15:0] new_pixel
);

	// Width that holds any saturated frame dimension, and a compare width that
	// also holds an unclipped 12-bit position.
	localparam int DimW = $clog2(MAX_DIM + 1);
	localparam int CmpW = (DimW > 12) ? DimW : 12;
	localparam int RowW = 2 * DimW;
	localparam int SumW = (RowW > rgbcmp_pkg::IDX_W) ? RowW + 1 : rgbcmp_pkg::IDX_W + 1;

	// The pipeline never stalls, so both channels are always ready.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic signed [10:0] origin_x_q;
	logic signed [10:0] origin_y_q;
	logic [10:0]        dest_width_q;
	logic [10:0]        dest_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			dest_width_q  <= rgbcmp_pkg::DEST_WIDTH_RESET;
			dest_height_q <= rgbcmp_pkg::DEST_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rgbcmp_pkg::reg_index_t'(cfg_index))
				rgbcmp_pkg::REG_ORIGIN_X:    origin_x_q    <= $signed(cfg_wdata);
				rgbcmp_pkg::REG_ORIGIN_Y:    origin_y_q    <= $signed(cfg_wdata);
				rgbcmp_pkg::REG_DEST_WIDTH:  dest_width_q  <= cfg_wdata;
				rgbcmp_pkg::REG_DEST_HEIGHT: dest_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Frame size saturated to MAX_DIM. Truncation in the cast only drops bits
	// of values that are already known to be no larger than MAX_DIM.
	logic [DimW-1:0] width_sat;
	logic [DimW-1:0] height_sat;

	always_comb begin
		width_sat  = (int'(dest_width_q) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(dest_width_q);
		height_sat = (int'(dest_height_q) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(dest_height_q);
	end

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic [9:0]  rel_x_s1;
	logic [9:0]  rel_y_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;
	logic [7:0]  alpha_s1;
	logic [15:0] dpix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			rel_x_s1 <= rel_x;
			rel_y_s1 <= rel_y;
			red_s1   <= src_red;
			green_s1 <= src_green;
			blue_s1  <= src_blue;
			alpha_s1 <= src_alpha;
			dpix_s1  <= dest_pixel;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 logic: placement, clipping, row offset and channel products.
	// ------------------------------------------------------------------
	logic signed [11:0] pos_x;
	logic signed [11:0] pos_y;
	logic [CmpW-1:0]    pos_x_u;
	logic [CmpW-1:0]    pos_y_u;
	logic               in_frame;
	logic               draw;
	logic               opaque;
	logic [RowW-1:0]    row_base;
	logic [7:0]         inv_alpha;
	logic [7:0]         src_chan [3];
	logic [7:0]         dst_chan [3];
	logic [15:0]        mix_sum  [3];

	always_comb begin
		pos_x = $signed({origin_x_q[10], origin_x_q}) + $signed({2'b00, rel_x_s1});
		pos_y = $signed({origin_y_q[10], origin_y_q}) + $signed({2'b00, rel_y_s1});
		pos_x_u = CmpW'($unsigned(pos_x));
		pos_y_u = CmpW'($unsigned(pos_y));

		in_frame = !pos_x[11] && !pos_y[11]
			&& (pos_x_u < CmpW'(width_sat)) && (pos_y_u < CmpW'(height_sat));
		draw   = in_frame && (alpha_s1 >= rgbcmp_pkg::ALPHA_MIN);
		opaque = alpha_s1 >= rgbcmp_pkg::ALPHA_OPAQUE;

		// Only meaningful for an unclipped pixel, where y fits in DimW bits.
		row_base = RowW'(DimW'(pos_y_u)) * RowW'(width_sat);

		// Channel lanes in red, green, blue order. The destination is widened
		// by a plain shift left, without replicating the top bits.
		src_chan[0] = red_s1;
		src_chan[1] = green_s1;
		src_chan[2] = blue_s1;
		dst_chan[0] = {dpix_s1[15:11], 3'b000};
		dst_chan[1] = {dpix_s1[10:5], 2'b00};
		dst_chan[2] = {dpix_s1[4:0], 3'b000};

		inv_alpha = rgbcmp_pkg::ALPHA_FULL - alpha_s1;
		for (int c = 0; c < 3; c++) begin
			mix_sum[c] = ({8'd0, src_chan[c]} * {8'd0, alpha_s1})
				+ ({8'd0, dst_chan[c]} * {8'd0, inv_alpha});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 register.
	// ------------------------------------------------------------------
	logic            valid_s2;
	logic            draw_s2;
	logic            opaque_s2;
	logic [RowW-1:0] row_base_s2;
	logic [DimW-1:0] col_s2;
	logic [15:0]     opaque_pix_s2;
	logic [15:0]     mix_sum_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			draw_s2       <= draw;
			opaque_s2     <= opaque;
			row_base_s2   <= row_base;
			col_s2        <= DimW'(pos_x_u);
			opaque_pix_s2 <= rgbcmp_pkg::pack565(red_s1, green_s1, blue_s1);
			for (int c = 0; c < 3; c++) begin
				mix_sum_s2[c] <= mix_sum[c];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 logic: divide by 255, repack and finish the index.
	// ------------------------------------------------------------------
	logic [SumW-1:0] index_full;
	logic [15:0]     blend_pix;
	logic [15:0]     pix_next;

	always_comb begin
		index_full = SumW'(row_base_s2) + SumW'(col_s2);
		blend_pix  = rgbcmp_pkg::pack565(rgbcmp_pkg::div255(mix_sum_s2[0]),
			rgbcmp_pkg::div255(mix_sum_s2[1]), rgbcmp_pkg::div255(mix_sum_s2[2]));
		pix_next   = opaque_s2 ? opaque_pix_s2 : blend_pix;
	end

	// Result register. A pixel that is not written reports all fields zero.
	logic        result_valid_q;
	logic        write_enable_q;
	logic [19:0] dest_index_q;
	logic [15:0] new_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			write_enable_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s2;
			write_enable_q <= valid_s2 && draw_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			dest_index_q <= draw_s2 ? index_full[19:0] : '0;
			new_pixel_q  <= draw_s2 ? pix_next : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign write_enable = write_enable_q;
	assign dest_index   = dest_index_q;
	assign new_pixel    = new_pixel_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// Every accepted transaction produces its result once it has passed the stage 1, stage 2 and result registers.
	`RGBCMP_ASSERT_AFTER(a_latency, start && !busy, 3, result_valid, "result strobe missing after accept")
	// A write is only flagged on a result cycle.
	`RGBCMP_ASSERT_NOW(a_we_in_result, write_enable, result_valid, "write_enable outside a result")
	// A skipped pixel carries zero index and zero pixel.
	`RGBCMP_ASSERT_NOW(a_skip_zero, result_valid && !write_enable, (dest_index == '0) && (new_pixel == '0), "skipped pixel has nonzero fields")
	// Results come only from a multiply-stage transaction in the cycle before.
	`RGBCMP_ASSERT_NOW(a_result_src, result_valid, $past(valid_s2), "result without a stage 2 transaction")

endmodule
